>>> hdl/bvm_pkg.sv
// Shared types and constants for the byte vocabulary map.
package bvm_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int ADDR_W = 8;
	localparam int ID_W = 9;

	// Request codes
	localparam logic [1:0] REQ_ADD   = 2'd0;
	localparam logic [1:0] REQ_BUILD = 2'd1;
	localparam logic [1:0] REQ_B2I   = 2'd2;
	localparam logic [1:0] REQ_I2B   = 2'd3;

	// Result kinds
	localparam logic [1:0] KIND_BUILD = 2'd0;
	localparam logic [1:0] KIND_B2I   = 2'd1;
	localparam logic [1:0] KIND_I2B   = 2'd2;

	localparam logic [7:0] NEWLINE_BYTE = 8'd10;
	localparam logic [7:0] UNKNOWN_BYTE = 8'd63;
	localparam logic [ID_W-1:0] NO_ID = 9'h1FF;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic              data;
	} flag_wr_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [ID_W-1:0]   data;
	} id_wr_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} byte_wr_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
	} rd_req_t;

	typedef struct packed {
		logic idle;
		logic done;
	} ctl_stat_t;

endpackage

>>> hdl/byte_vocabulary_map.sv
// Top level of the byte vocabulary map: request decode, lookup path and result register.
//
//  channel | direction | handshake         | fields
//  in      | input     | in_valid/in_stall | req_type, data_byte, symbol_id
//  out     | output    | out_valid/out_stall | result_kind, vocab_count, symbol_id_out, byte_out
//
// Add and lookup items are taken one per cycle while the sequencer is idle and no result is
// stalled; a lookup result passes the registered table read, then the result register.
// A build item holds in_stall while the sequencer makes one seen-flag memory read per byte
// value (256), then runs the empty-corpus fixup and waits for its result to be taken.
// After reset a clearing pass fills the seen-flag and byte-to-id tables, with in_stall high.
// A stalled result holds the output register and, once the lookup stage is full, the input.
module byte_vocabulary_map import bvm_pkg::*; #(
	parameter int ALPHABET_SIZE = 256
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [1:0]             req_type,
	input  logic [7:0]             data_byte,
	input  logic [7:0]             symbol_id,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [1:0]             result_kind,
	output logic [ID_W-1:0]        vocab_count,
	output logic signed [ID_W-1:0] symbol_id_out,
	output logic [7:0]             byte_out
);

	localparam logic [ID_W-1:0] ALPHA_LIM = ID_W'(ALPHABET_SIZE);

	rd_req_t         seen_rd;
	flag_wr_t        ctl_seen_wr;
	id_wr_t          b2i_wr;
	byte_wr_t        i2b_wr;
	ctl_stat_t       stat;
	logic [ID_W-1:0] count;
	logic            seen_rd_data;
	logic [ID_W-1:0] b2i_rd_data;
	logic [7:0]      i2b_rd_data;

	logic            in_accept;
	logic            out_free;
	logic            add_wr;
	logic            b2i_rd_en;
	logic            i2b_rd_en;
	logic            done_take;
	logic            seen_wr_en;
	logic [ADDR_W-1:0] seen_wr_addr;
	logic            seen_wr_data;

	logic            lk_v_s1;
	logic            lk_i2b_s1;
	logic            lk_ok_s1;

	logic            out_v_q;
	logic [1:0]      kind_q;
	logic [ID_W-1:0] count_q;
	logic [ID_W-1:0] id_q;
	logic [7:0]      byte_q;

	assign out_free = !out_v_q || !out_stall;
	assign in_stall = !stat.idle || (lk_v_s1 && !out_free) ||
		((req_type == REQ_BUILD) && lk_v_s1);
	assign in_accept = in_valid && !in_stall;

	assign add_wr = in_accept && (req_type == REQ_ADD) && ({1'b0, data_byte} < ALPHA_LIM);
	assign b2i_rd_en = in_accept && (req_type == REQ_B2I);
	assign i2b_rd_en = in_accept && (req_type == REQ_I2B);
	assign done_take = stat.done && out_free && !lk_v_s1;

	// adds only come in while the sequencer is idle, so the ports never collide
	assign seen_wr_en = ctl_seen_wr.en || add_wr;
	assign seen_wr_addr = ctl_seen_wr.en ? ctl_seen_wr.addr : data_byte;
	assign seen_wr_data = ctl_seen_wr.en ? ctl_seen_wr.data : 1'b1;

	bvm_ctrl #(
		.ALPHABET_SIZE(ALPHABET_SIZE)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.build_start (in_accept && (req_type == REQ_BUILD)),
		.done_take   (done_take),
		.seen_rd_data(seen_rd_data),
		.seen_rd     (seen_rd),
		.seen_wr     (ctl_seen_wr),
		.b2i_wr      (b2i_wr),
		.i2b_wr      (i2b_wr),
		.count       (count),
		.stat        (stat)
	);

	bvm_ram #(
		.WIDTH(1),
		.DEPTH(TABLE_DEPTH)
	) u_seen_ram (
		.clk    (clk),
		.wr_en  (seen_wr_en),
		.wr_addr(seen_wr_addr),
		.wr_data(seen_wr_data),
		.rd_en  (seen_rd.en),
		.rd_addr(seen_rd.addr),
		.rd_data(seen_rd_data)
	);

	bvm_ram #(
		.WIDTH(ID_W),
		.DEPTH(TABLE_DEPTH)
	) u_b2i_ram (
		.clk    (clk),
		.wr_en  (b2i_wr.en),
		.wr_addr(b2i_wr.addr),
		.wr_data(b2i_wr.data),
		.rd_en  (b2i_rd_en),
		.rd_addr(data_byte),
		.rd_data(b2i_rd_data)
	);

	bvm_ram #(
		.WIDTH(8),
		.DEPTH(TABLE_DEPTH)
	) u_i2b_ram (
		.clk    (clk),
		.wr_en  (i2b_wr.en),
		.wr_addr(i2b_wr.addr),
		.wr_data(i2b_wr.data),
		.rd_en  (i2b_rd_en),
		.rd_addr(symbol_id),
		.rd_data(i2b_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lk_v_s1 <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (lk_v_s1 && out_free) begin
				lk_v_s1 <= 1'b0;
			end
			if (b2i_rd_en || i2b_rd_en) begin
				lk_v_s1 <= 1'b1;
			end
			if (out_free) begin
				out_v_q <= lk_v_s1 || stat.done;
			end
		end
	end

	// the read data stays put while the stage waits: no new read is issued then
	always_ff @(posedge clk) begin
		if (b2i_rd_en || i2b_rd_en) begin
			lk_i2b_s1 <= i2b_rd_en;
			lk_ok_s1 <= i2b_rd_en ? ({1'b0, symbol_id} < count) :
				({1'b0, data_byte} < ALPHA_LIM);
		end
		if (out_free) begin
			count_q <= count;
			if (lk_v_s1 && lk_i2b_s1) begin
				kind_q <= KIND_I2B;
				id_q <= '0;
				byte_q <= lk_ok_s1 ? i2b_rd_data : UNKNOWN_BYTE;
			end else if (lk_v_s1) begin
				kind_q <= KIND_B2I;
				id_q <= lk_ok_s1 ? b2i_rd_data : NO_ID;
				byte_q <= '0;
			end else begin
				kind_q <= KIND_BUILD;
				id_q <= '0;
				byte_q <= '0;
			end
		end
	end

	assign out_valid = out_v_q;
	assign result_kind = kind_q;
	assign vocab_count = count_q;
	assign symbol_id_out = $signed(id_q);
	assign byte_out = byte_q;

endmodule

>>> hdl/bvm_ram.sv
// Generic simple dual-port RAM with registered read.
module bvm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> hdl/bvm_ctrl.sv
// Sequencer for the reset clearing pass and the vocabulary build sweep.
module bvm_ctrl import bvm_pkg::*; #(
	parameter int ALPHABET_SIZE = 256
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            build_start,
	input  logic            done_take,
	input  logic            seen_rd_data,
	output rd_req_t         seen_rd,
	output flag_wr_t        seen_wr,
	output id_wr_t          b2i_wr,
	output byte_wr_t        i2b_wr,
	output logic [ID_W-1:0] count,
	output ctl_stat_t       stat
);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_SWEEP = 3'd2;
	localparam logic [2:0] ST_FIX   = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	localparam logic [ID_W-1:0] ALPHA_LIM = ID_W'(ALPHABET_SIZE);

	logic [2:0]        state_q;
	logic [ID_W-1:0]   addr_q;
	logic [ID_W-1:0]   count_q;
	logic              sw_v_s1;
	logic [ADDR_W-1:0] sw_b_s1;
	logic              hit;
	logic              empty_fix;

	assign hit = sw_v_s1 && seen_rd_data && ({1'b0, sw_b_s1} < ALPHA_LIM);
	assign empty_fix = (state_q == ST_FIX) && (count_q == '0);

	assign count = count_q;
	assign stat.idle = (state_q == ST_IDLE);
	assign stat.done = (state_q == ST_DONE);

	assign seen_rd.en = (state_q == ST_SWEEP) && !addr_q[ADDR_W];
	assign seen_rd.addr = addr_q[ADDR_W-1:0];

	always_comb begin
		seen_wr = '0;
		b2i_wr = '0;
		i2b_wr = '0;
		if (state_q == ST_CLEAR) begin
			seen_wr.en = 1'b1;
			seen_wr.addr = addr_q[ADDR_W-1:0];
			b2i_wr.en = 1'b1;
			b2i_wr.addr = addr_q[ADDR_W-1:0];
			b2i_wr.data = NO_ID;
		end else if (sw_v_s1) begin
			// drop the seen flag and rebuild the entry
			seen_wr.en = 1'b1;
			seen_wr.addr = sw_b_s1;
			b2i_wr.en = 1'b1;
			b2i_wr.addr = sw_b_s1;
			b2i_wr.data = hit ? count_q : NO_ID;
			i2b_wr.en = hit;
			i2b_wr.addr = count_q[ADDR_W-1:0];
			i2b_wr.data = sw_b_s1;
		end else if (empty_fix) begin
			b2i_wr.en = ({1'b0, NEWLINE_BYTE} < ALPHA_LIM);
			b2i_wr.addr = NEWLINE_BYTE;
			b2i_wr.data = '0;
			i2b_wr.en = 1'b1;
			i2b_wr.addr = '0;
			i2b_wr.data = NEWLINE_BYTE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			addr_q <= '0;
			count_q <= '0;
			sw_v_s1 <= 1'b0;
		end else begin
			sw_v_s1 <= 1'b0;
			if (hit) begin
				count_q <= count_q + 1'b1;
			end
			unique case (state_q)
				ST_CLEAR: begin
					if (addr_q[ADDR_W-1:0] == '1) begin
						addr_q <= '0;
						state_q <= ST_IDLE;
					end else begin
						addr_q <= addr_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (build_start) begin
						addr_q <= '0;
						count_q <= '0;
						state_q <= ST_SWEEP;
					end
				end
				ST_SWEEP: begin
					if (!addr_q[ADDR_W]) begin
						sw_v_s1 <= 1'b1;
						addr_q <= addr_q + 1'b1;
					end else begin
						state_q <= ST_FIX;
					end
				end
				ST_FIX: begin
					if (count_q == '0) begin
						count_q <= ID_W'(1);
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (done_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		sw_b_s1 <= addr_q[ADDR_W-1:0];
	end

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the byte vocabulary map: stimulus queue, driver, monitor, predictor.
`timescale 1ns / 1ps

module testbench;
	import bvm_pkg::*;

	localparam int ALPHABET = 256;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [1:0] req;
		logic [7:0] data;
		logic [7:0] id;
	} vocab_req_t;

	typedef struct packed {
		logic [1:0]             kind;
		logic [ID_W-1:0]        count;
		logic signed [ID_W-1:0] sym;
		logic [7:0]             chr;
	} vocab_answer_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	logic [1:0]             req_type = '0;
	logic [7:0]             data_byte = '0;
	logic [7:0]             symbol_id = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic [1:0]             result_kind;
	logic [ID_W-1:0]        vocab_count;
	logic signed [ID_W-1:0] symbol_id_out;
	logic [7:0]             byte_out;

	vocab_req_t    pending_reqs[$];
	vocab_answer_t expected_answers[$];
	int            mismatch_count = 0;
	int            cycle_count = 0;
	int            gap_left = 0;
	int            stall_left = 0;

	// Predictor state: corpus flags, both translation tables and the vocabulary size
	logic                   corpus_seen [ALPHABET];
	logic signed [ID_W-1:0] byte_ids [TABLE_DEPTH];
	logic [7:0]             id_bytes [TABLE_DEPTH];
	logic [ID_W-1:0]        known_count;

	// The cycle count is cut into equal stretches; every third one runs without gaps or stalls
	wire calm = ((cycle_count / 2000) % 3) == 2;

	byte_vocabulary_map #(.ALPHABET_SIZE(ALPHABET)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.data_byte(data_byte),
		.symbol_id(symbol_id),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.result_kind(result_kind),
		.vocab_count(vocab_count),
		.symbol_id_out(symbol_id_out),
		.byte_out(byte_out)
	);

	function automatic int pick_pause();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic void queue_req(input logic [1:0] req, input logic [7:0] data,
			input logic [7:0] id);
		vocab_req_t r;
		r.req = req;
		r.data = data;
		r.id = id;
		pending_reqs.push_back(r);
	endfunction

	// Update the vocabulary state for one accepted item and queue its answer, if any
	function void predict_vocab_answer(input vocab_req_t r);
		vocab_answer_t a;
		a.kind = KIND_BUILD;
		a.sym = '0;
		a.chr = '0;
		case (r.req)
			REQ_ADD: begin
				if (int'(r.data) < ALPHABET)
					corpus_seen[r.data] = 1'b1;
				return;
			end
			REQ_BUILD: begin
				known_count = '0;
				for (int b = 0; b < TABLE_DEPTH; b++)
					byte_ids[b] = NO_ID;
				for (int b = 0; b < ALPHABET; b++) begin
					if (corpus_seen[b]) begin
						byte_ids[b] = known_count;
						id_bytes[known_count[7:0]] = b[7:0];
						known_count++;
					end
				end
				// Empty corpus: newline becomes the only symbol
				if (known_count == 0) begin
					if (int'(NEWLINE_BYTE) < ALPHABET)
						byte_ids[NEWLINE_BYTE] = '0;
					id_bytes[0] = NEWLINE_BYTE;
					known_count = 1;
				end
				for (int b = 0; b < ALPHABET; b++)
					corpus_seen[b] = 1'b0;
			end
			REQ_B2I: begin
				a.kind = KIND_B2I;
				a.sym = (int'(r.data) < ALPHABET) ? byte_ids[r.data] : NO_ID;
			end
			default: begin
				a.kind = KIND_I2B;
				a.chr = ({1'b0, r.id} < known_count) ? id_bytes[r.id] : UNKNOWN_BYTE;
			end
		endcase
		a.count = known_count;
		expected_answers.push_back(a);
	endfunction

	function void check_field(input string name, input logic signed [9:0] want,
			input logic signed [9:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			mismatch_count++;
		end
	endfunction

	initial begin
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Driver: present the next pending item once the current one is taken
	always @(posedge clk or negedge arst_n) begin
		vocab_req_t r;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || !in_stall) begin
			if (in_valid)
				predict_vocab_answer('{req: req_type, data: data_byte, id: symbol_id});
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending_reqs.size() > 0) begin
				r = pending_reqs.pop_front();
				req_type <= r.req;
				data_byte <= r.data;
				symbol_id <= r.id;
				in_valid <= 1'b1;
				gap_left = calm ? 0 : pick_pause();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor: stall at random and compare each taken result with the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		vocab_answer_t a;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_answers.size() == 0) begin
					$display("%0t: unexpected result, kind %0d count %0d id %0d byte %0d",
						$time, result_kind, vocab_count, symbol_id_out, byte_out);
					mismatch_count++;
				end else begin
					a = expected_answers.pop_front();
					check_field("result_kind", a.kind, result_kind);
					check_field("vocab_count", a.count, vocab_count);
					check_field("symbol_id_out", a.sym, symbol_id_out);
					check_field("byte_out", a.chr, byte_out);
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				stall_left = calm ? 0 : pick_pause();
				out_stall <= (stall_left != 0);
				if (stall_left != 0)
					stall_left--;
			end
		end
	end

	initial begin
		logic [7:0] corpus_bytes[$];
		bit         picked [256];
		int         n_add;
		int         n_look;
		int         distinct;
		int         mode;
		logic [7:0] v;

		for (int b = 0; b < ALPHABET; b++)
			corpus_seen[b] = 1'b0;
		for (int b = 0; b < TABLE_DEPTH; b++) begin
			byte_ids[b] = NO_ID;
			id_bytes[b] = '0;
		end
		known_count = '0;

		// Lookups before any build, then an empty corpus
		queue_req(REQ_B2I, 8'd0, 8'd0);
		queue_req(REQ_B2I, 8'd255, 8'd255);
		queue_req(REQ_I2B, 8'd0, 8'd0);
		queue_req(REQ_I2B, 8'd255, 8'd255);
		queue_req(REQ_BUILD, 8'd0, 8'd0);
		queue_req(REQ_B2I, NEWLINE_BYTE, 8'd0);
		queue_req(REQ_B2I, 8'd11, 8'd0);
		queue_req(REQ_I2B, 8'd0, 8'd0);
		queue_req(REQ_I2B, 8'd0, 8'd1);
		// Small corpus with extremes and a duplicate
		queue_req(REQ_ADD, 8'd0, 8'd255);
		queue_req(REQ_ADD, 8'd255, 8'd0);
		queue_req(REQ_ADD, 8'd170, 8'd85);
		queue_req(REQ_ADD, 8'd85, 8'd170);
		queue_req(REQ_ADD, 8'd170, 8'd0);
		queue_req(REQ_BUILD, 8'd255, 8'd255);
		queue_req(REQ_B2I, 8'd0, 8'd0);
		queue_req(REQ_B2I, 8'd255, 8'd0);
		queue_req(REQ_B2I, 8'd1, 8'd0);
		queue_req(REQ_I2B, 8'd0, 8'd3);
		queue_req(REQ_I2B, 8'd0, 8'd4);
		queue_req(REQ_I2B, 8'd0, 8'd255);
		// Flags were cleared by the last build, so this one sees an empty corpus
		queue_req(REQ_BUILD, 8'd0, 8'd0);
		queue_req(REQ_I2B, 8'd0, 8'd0);
		queue_req(REQ_B2I, 8'd170, 8'd0);

		// Full alphabet once, so every id up to 255 maps to a byte
		for (int b = 0; b < 256; b++)
			queue_req(REQ_ADD, b[7:0], 8'($urandom));
		queue_req(REQ_BUILD, 8'($urandom), 8'($urandom));
		queue_req(REQ_I2B, 8'($urandom), 8'd255);
		queue_req(REQ_B2I, 8'd255, 8'($urandom));
		for (int k = 0; k < 8; k++) begin
			queue_req(REQ_I2B, 8'($urandom), 8'($urandom));
			queue_req(REQ_B2I, 8'($urandom), 8'($urandom));
		end

		while (pending_reqs.size() < 650) begin
			mode = $urandom_range(0, 9);
			if (mode == 0) begin
				// Noise: any request type with random content
				n_look = $urandom_range(3, 12);
				for (int k = 0; k < n_look; k++)
					queue_req(2'($urandom), 8'($urandom), 8'($urandom));
			end else begin
				corpus_bytes.delete();
				for (int b = 0; b < 256; b++)
					picked[b] = 1'b0;
				distinct = 0;
				n_add = (mode == 1) ? $urandom_range(30, 80) : $urandom_range(0, 16);
				for (int k = 0; k < n_add; k++) begin
					if (corpus_bytes.size() > 0 && $urandom_range(0, 4) == 0)
						v = corpus_bytes[$urandom_range(0, corpus_bytes.size() - 1)];
					else
						v = 8'($urandom);
					if (!picked[v]) begin
						picked[v] = 1'b1;
						distinct++;
					end
					corpus_bytes.push_back(v);
					queue_req(REQ_ADD, v, 8'($urandom));
				end
				queue_req(REQ_BUILD, 8'($urandom), 8'($urandom));
				n_look = $urandom_range(4, 20);
				for (int k = 0; k < n_look; k++) begin
					if ($urandom_range(0, 1) == 0) begin
						if (corpus_bytes.size() > 0 && $urandom_range(0, 9) < 7)
							v = corpus_bytes[$urandom_range(0, corpus_bytes.size() - 1)];
						else
							v = 8'($urandom);
						queue_req(REQ_B2I, v, 8'($urandom));
					end else begin
						if ($urandom_range(0, 9) < 8)
							v = 8'($urandom_range(0, distinct));
						else
							v = 8'($urandom);
						queue_req(REQ_I2B, 8'($urandom), v);
					end
				end
			end
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Poll once a cycle until every item is sent and every result is taken
		while (pending_reqs.size() != 0 || in_valid || expected_answers.size() != 0)
			@(posedge clk);
		// Let a trailing build or stray result show up before judging
		repeat (400) @(posedge clk);
		if (mismatch_count == 0 && expected_answers.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
